>>> src/rdb_pkg.sv
// shared types, constants and codes of the read depth binning block
package rdb_pkg;

  // default sizes of the top level parameters
  localparam int CHROM_COUNT_DEF = 32;
  localparam int SLOTS_DEF       = 8192;
  localparam int COUNT_W_DEF     = 32;

  // window register
  localparam int WIN_W       = 21;
  localparam logic [WIN_W-1:0] WIN_MIN   = 21'd2;
  localparam logic [WIN_W-1:0] WIN_MAX   = 21'd1048576;
  localparam logic [WIN_W-1:0] WIN_RESET = 21'd1000;

  // field widths
  localparam int CHROM_W = 5;
  localparam int POS_W   = 31;
  localparam int LEN_W   = 16;
  localparam int COORD_W = 32;
  localparam int OUT_CNT_W = 32;
  localparam int STATUS_W  = 2;

  // stream widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  // divider widths
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 22;
  localparam int SLOT_W = NUM_W + 1;

  // widest table index over the parameter range
  localparam int IDX_W_MAX = 28;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OFFGRID = 2'd2;

  // classified operation handed from front to back
  typedef struct packed {
    logic                  query;
    logic                  alt;
    logic                  ok_a;
    logic                  ok_b;
    logic [IDX_W_MAX-1:0]  idx_a;
    logic [IDX_W_MAX-1:0]  idx_b;
    logic [STATUS_W-1:0]   status;
  } op_t;

endpackage

>>> src/rdb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module rdb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rdb_pkg::NUM_W-1:0] num,
  input  logic [rdb_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [rdb_pkg::NUM_W-1:0] quo,
  output logic                      rem_zero
);

  localparam int NW = rdb_pkg::NUM_W;
  localparam int DW = rdb_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // trial subtraction of one step
  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done     = done_r;
  assign quo      = quo_r;
  assign rem_zero = (rem_r == '0);

endmodule

>>> src/rdb_front.sv
// front end: accepts items, works out window slots and classifies them
module rdb_front #(
  parameter int CHROM_COUNT     = rdb_pkg::CHROM_COUNT_DEF,
  parameter int SLOTS_PER_CHROM = rdb_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  logic [rdb_pkg::WIN_W-1:0]     win,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [rdb_pkg::CHROM_W-1:0]   chrom_id,
  input  logic [rdb_pkg::POS_W-1:0]     read_pos,
  input  logic [rdb_pkg::LEN_W-1:0]     read_length,
  input  logic                          has_alt_hits,
  input  logic [rdb_pkg::COORD_W-1:0]   query_coord,
  output logic                          push,
  input  logic                          full,
  output rdb_pkg::op_t                  op
);

  localparam int NW    = rdb_pkg::NUM_W;
  localparam int DW    = rdb_pkg::DEN_W;
  localparam int SW    = rdb_pkg::SLOT_W;
  localparam int IDX_W = $clog2(CHROM_COUNT * SLOTS_PER_CHROM);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV1 = 4'b0010,
    F_DIV2 = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r;
  logic    start_r;
  logic    cmd_r;
  logic    alt_r;
  logic [rdb_pkg::CHROM_W-1:0] chrom_r;
  logic [NW-1:0] n1_r, n2_r;
  logic [DW-1:0] d1_r, d2_r;
  logic          neg_a_r, neg_b_r;
  logic [NW-1:0] q1_r, q2_r;
  logic          r1z_r, r2z_r;

  logic          acc;
  logic [31:0]   mid;
  logic [NW-1:0] w_ext;
  logic signed [NW-1:0] dq, eq;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic          div_rz;

  assign in_ready = (state_r == F_IDLE) && enable;
  assign acc      = in_ready && in_valid;

  // dividends and divisors of both steps
  assign mid   = {1'b0, read_pos} + 32'(read_length >> 1);
  assign w_ext = NW'(win);
  assign dq    = signed'({{(NW-rdb_pkg::COORD_W){query_coord[rdb_pkg::COORD_W-1]}},
                          query_coord}) - NW'(1);
  assign eq    = dq + signed'(NW'(win >> 1));

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r   <= cmd;
      alt_r   <= has_alt_hits;
      chrom_r <= chrom_id;
      if (cmd == rdb_pkg::CMD_COUNT) begin
        n1_r    <= NW'(mid);
        d1_r    <= DW'(win);
        n2_r    <= NW'({mid, 1'b0}) + w_ext;
        d2_r    <= DW'({win, 1'b0});
        neg_a_r <= 1'b0;
        neg_b_r <= 1'b0;
      end else begin
        n1_r    <= dq[NW-1] ? '0 : dq;
        d1_r    <= DW'(win);
        n2_r    <= eq[NW-1] ? '0 : eq;
        d2_r    <= DW'(win);
        neg_a_r <= dq[NW-1];
        neg_b_r <= eq[NW-1];
      end
    end
  end

  // shared divider
  rdb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .num      ((state_r == F_DIV1) ? n1_r : n2_r),
    .den      ((state_r == F_DIV1) ? d1_r : d2_r),
    .done     (div_done),
    .quo      (div_q),
    .rem_zero (div_rz)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        F_IDLE: begin
          if (acc) begin
            state_r <= F_DIV1;
            start_r <= 1'b1;
          end
        end
        F_DIV1: begin
          if (div_done) begin
            state_r <= F_DIV2;
            start_r <= 1'b1;
          end
        end
        F_DIV2: begin
          if (div_done) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // quotients
  always_ff @(posedge clk) begin
    if (div_done && state_r == F_DIV1) begin
      q1_r  <= div_q;
      r1z_r <= div_rz;
    end
    if (div_done && state_r == F_DIV2) begin
      q2_r  <= div_q;
      r2z_r <= div_rz;
    end
  end

  // classification
  logic [SW-1:0] slot_a, slot_b, slot_q;
  logic          chrom_ok, ok_a, ok_b, found_a, found_b, ok_q;
  logic [IDX_W-1:0] base;

  assign slot_a   = {q1_r, 1'b1};
  assign slot_b   = {q2_r, 1'b0};
  assign chrom_ok = 9'(chrom_r) < 9'(CHROM_COUNT);
  assign ok_a     = chrom_ok && (slot_a < SW'(SLOTS_PER_CHROM));
  assign ok_b     = chrom_ok && (slot_b < SW'(SLOTS_PER_CHROM));
  assign found_a  = !neg_a_r && r1z_r;
  assign found_b  = !neg_b_r && r2z_r;
  assign slot_q   = found_a ? slot_a : slot_b;
  assign ok_q     = (found_a || found_b) && chrom_ok && (slot_q < SW'(SLOTS_PER_CHROM));
  assign base     = IDX_W'(chrom_r) * IDX_W'(SLOTS_PER_CHROM);

  always_comb begin
    op       = '0;
    op.query = cmd_r;
    op.alt   = alt_r;
    if (cmd_r == rdb_pkg::CMD_COUNT) begin
      op.ok_a   = ok_a;
      op.ok_b   = ok_b;
      op.idx_a  = rdb_pkg::IDX_W_MAX'(base + IDX_W'(slot_a));
      op.idx_b  = rdb_pkg::IDX_W_MAX'(base + IDX_W'(slot_b));
      op.status = (ok_a && ok_b) ? rdb_pkg::ST_OK : rdb_pkg::ST_RANGE;
    end else begin
      op.ok_a   = ok_q;
      op.ok_b   = 1'b0;
      op.idx_a  = rdb_pkg::IDX_W_MAX'(base + IDX_W'(slot_q));
      op.idx_b  = '0;
      op.status = ok_q ? rdb_pkg::ST_OK : rdb_pkg::ST_OFFGRID;
    end
  end

  assign push = (state_r == F_PUSH) && !full;

endmodule

>>> src/rdb_queue.sv
// short queue of classified operations between front and back
module rdb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rdb_pkg::op_t  din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rdb_pkg::op_t  dout
);

  localparam int D  = rdb_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;

  rdb_pkg::op_t    ent_r [D];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW+1)'(D));
  assign empty = (cnt_r == '0);
  assign dout  = ent_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(D - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(D - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end

endmodule

>>> src/rdb_back.sv
// back end: count tables, clearing pass, updates, lookups and result register
module rdb_back #(
  parameter int CHROM_COUNT     = rdb_pkg::CHROM_COUNT_DEF,
  parameter int SLOTS_PER_CHROM = rdb_pkg::SLOTS_DEF,
  parameter int COUNT_WIDTH     = rdb_pkg::COUNT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  output logic                            ready_up,
  input  logic                            empty,
  input  rdb_pkg::op_t                    op,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rdb_pkg::OUT_TDATA_W-1:0] out_data
);

  localparam int DEPTH = CHROM_COUNT * SLOTS_PER_CHROM;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = COUNT_WIDTH;

  typedef enum logic [6:0] {
    B_CLR  = 7'b0000001,
    B_IDLE = 7'b0000010,
    B_RDA  = 7'b0000100,
    B_UPDA = 7'b0001000,
    B_RDB  = 7'b0010000,
    B_UPDB = 7'b0100000,
    B_RESP = 7'b1000000
  } bstate_t;

  bstate_t        state_r;
  rdb_pkg::op_t   op_r;
  logic [IDX_W-1:0] clr_r;
  logic [CW-1:0]  na_mem [DEPTH];
  logic [CW-1:0]  ah_mem [DEPTH];
  logic [CW-1:0]  na_rd_r, ah_rd_r;
  logic [CW-1:0]  res_na_r, res_ah_r;
  logic           out_valid_r;
  logic [rdb_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [IDX_W-1:0] ra, wa;
  logic             we_na, we_ah;
  logic [CW-1:0]    wd, cur, inc;
  logic             do_wr, out_free;

  assign ready_up = (state_r != B_CLR);
  assign pop      = (state_r == B_IDLE) && !empty;
  assign out_free = !out_valid_r || out_ready;

  // read address and increment of the selected table
  assign ra  = (state_r == B_RDB) ? op_r.idx_b[IDX_W-1:0] : op_r.idx_a[IDX_W-1:0];
  assign cur = op_r.alt ? ah_rd_r : na_rd_r;
  assign inc = (cur == '1) ? cur : cur + 1'b1;

  always_comb begin
    do_wr = 1'b0;
    wa    = clr_r;
    wd    = '0;
    we_na = 1'b0;
    we_ah = 1'b0;
    case (state_r)
      B_CLR: begin
        we_na = 1'b1;
        we_ah = 1'b1;
      end
      B_UPDA: begin
        do_wr = !op_r.query && op_r.ok_a;
        wa    = op_r.idx_a[IDX_W-1:0];
        wd    = inc;
      end
      B_UPDB: begin
        do_wr = op_r.ok_b;
        wa    = op_r.idx_b[IDX_W-1:0];
        wd    = inc;
      end
      default: do_wr = 1'b0;
    endcase
    if (do_wr) begin
      we_na = !op_r.alt;
      we_ah = op_r.alt;
    end
  end

  // count tables
  always_ff @(posedge clk) begin
    if (we_na) na_mem[wa] <= wd;
    na_rd_r <= na_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (we_ah) ah_mem[wa] <= wd;
    ah_rd_r <= ah_mem[ra];
  end

  // sequencer, clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r   <= '0;
    end else begin
      case (state_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(DEPTH - 1)) state_r <= B_IDLE;
        end
        B_IDLE: if (!empty) state_r <= B_RDA;
        B_RDA:  state_r <= B_UPDA;
        B_UPDA: state_r <= op_r.query ? B_RESP : B_RDB;
        B_RDB:  state_r <= B_UPDB;
        B_UPDB: state_r <= B_RESP;
        B_RESP: if (out_free) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // operation and lookup results
  always_ff @(posedge clk) begin
    if (pop) op_r <= op;
    if (state_r == B_UPDA) begin
      res_na_r <= (op_r.query && op_r.ok_a) ? na_rd_r : '0;
      res_ah_r <= (op_r.query && op_r.ok_a) ? ah_rd_r : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_RESP && out_free) begin
      out_data_r <= {6'b0, op_r.status,
                     rdb_pkg::OUT_CNT_W'(res_ah_r), rdb_pkg::OUT_CNT_W'(res_na_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/windowed_read_depth_binning.sv
// top level of the windowed read depth binning block
// Usage: the in_ stream carries commands. tuser 0 counts one mapped read in its
// aligned and offset windows of the table that has_alt_hits selects; tuser 1
// looks up one window start coordinate and returns both tables' counts.
// Every command gives exactly one result transfer on the out_ stream with the
// two counts and a status (ok, read slot out of range, query off grid).
// cfg_ takes the window width; the user must see that it is written only while
// the block is idle, as the block itself does not enforce this. The front end
// runs two divisions on one bit-serial divider and takes no new command until
// it has handed the current one to the queue; the back end reads and updates
// the tables in its RDA and UPDA states, and for a count also in RDB and UPDB,
// before the result register.
// Reset: synchronous, active low. Afterwards a clearing pass zeroes both
// tables, one entry per cycle, CHROM_COUNT*SLOTS_PER_CHROM entries (262144 at
// the defaults); in_tready stays low until it ends.
// Stall: in_tready is low while the front end works on a command; a stalled
// result holds the back end, the queue takes two classified commands and a
// third waits in the front end before no further command is taken.
module windowed_read_depth_binning #(
  parameter int CHROM_COUNT     = rdb_pkg::CHROM_COUNT_DEF,
  parameter int SLOTS_PER_CHROM = rdb_pkg::SLOTS_DEF,
  parameter int COUNT_WIDTH     = rdb_pkg::COUNT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rdb_pkg::WIN_W-1:0]       cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // chrom_id[4:0], read_pos[35:5], read_length[51:36], has_alt_hits[52],
  // query_coord[84:53], zero fill
  input  logic [rdb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // no_alt_count[31:0], alt_hit_count[63:32], status[65:64], zero fill
  output logic [rdb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [rdb_pkg::WIN_W-1:0] win_r;
  logic [rdb_pkg::WIN_W-1:0] win_eff;
  logic         push, full, pop, empty, clear_done;
  rdb_pkg::op_t op_in, op_out;

  // window register and clamp
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= rdb_pkg::WIN_RESET;
    else if (cfg_valid) win_r <= cfg_data;
  end

  assign win_eff = (win_r < rdb_pkg::WIN_MIN) ? rdb_pkg::WIN_MIN :
                   (win_r > rdb_pkg::WIN_MAX) ? rdb_pkg::WIN_MAX : win_r;

  rdb_front #(
    .CHROM_COUNT     (CHROM_COUNT),
    .SLOTS_PER_CHROM (SLOTS_PER_CHROM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .enable       (clear_done),
    .win          (win_eff),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .cmd          (in_tuser),
    .chrom_id     (in_tdata[4:0]),
    .read_pos     (in_tdata[35:5]),
    .read_length  (in_tdata[51:36]),
    .has_alt_hits (in_tdata[52]),
    .query_coord  (in_tdata[84:53]),
    .push         (push),
    .full         (full),
    .op           (op_in)
  );

  rdb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (op_in),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .dout  (op_out)
  );

  rdb_back #(
    .CHROM_COUNT     (CHROM_COUNT),
    .SLOTS_PER_CHROM (SLOTS_PER_CHROM),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ready_up  (clear_done),
    .empty     (empty),
    .op        (op_out),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

>>> src/rdb_checker.sv
// port checker of the read depth binning block and its bind
module rdb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_ready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rdb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // status never holds the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] == rdb_pkg::ST_OK ||
                    out_tdata[65:64] == rdb_pkg::ST_RANGE ||
                    out_tdata[65:64] == rdb_pkg::ST_OFFGRID))
    else $error("bad status code");

  // failed commands return zero counts
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] != rdb_pkg::ST_OK |-> out_tdata[63:0] == '0)
    else $error("counts on failed command");

  // no result during or right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // configuration always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |-> cfg_ready)
    else $error("configuration refused");

endmodule

bind windowed_read_depth_binning rdb_checker u_rdb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/windowed_read_depth_binning_tb.sv
// testbench of the windowed read depth binning block: directed and random commands
module windowed_read_depth_binning_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NCHROM   = rdb_pkg::CHROM_COUNT_DEF;
  localparam int  NSLOT    = rdb_pkg::SLOTS_DEF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [31:0]                  no_alt;
    logic [31:0]                  alt_hit;
    logic [rdb_pkg::STATUS_W-1:0] status;
  } depth_result_t;

  // expected counts per window, kept in sparse tables
  class depth_scoreboard;
    logic [31:0]   no_alt_tab[longint];
    logic [31:0]   alt_tab[longint];
    depth_result_t awaited[$];
    longint        win;

    function new();
      win = rdb_pkg::WIN_RESET;
    endfunction

    function void set_window(logic [rdb_pkg::WIN_W-1:0] v);
      win = v;
      if (win < rdb_pkg::WIN_MIN) win = rdb_pkg::WIN_MIN;
      if (win > rdb_pkg::WIN_MAX) win = rdb_pkg::WIN_MAX;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // bump one counter, false when the slot is off the table
    function bit bump(bit alt, longint chrom, longint slot);
      longint idx;
      if (chrom >= NCHROM || slot >= NSLOT) return 0;
      idx = chrom * NSLOT + slot;
      if (alt) begin
        if (!alt_tab.exists(idx)) alt_tab[idx] = 0;
        if (alt_tab[idx] != CNT_MAX) alt_tab[idx]++;
      end else begin
        if (!no_alt_tab.exists(idx)) no_alt_tab[idx] = 0;
        if (no_alt_tab[idx] != CNT_MAX) no_alt_tab[idx]++;
      end
      return 1;
    endfunction

    // work out the result of one accepted command
    function void note_command(logic cmd, logic [4:0] chrom, logic [30:0] pos,
                               logic [15:0] len, logic alt, logic [31:0] coord);
      depth_result_t r;
      longint mid, sa, sb, c, d, e, slot, idx;
      bit ok_a, ok_b, found;
      r.no_alt = 0;
      r.alt_hit = 0;
      r.status = rdb_pkg::ST_OK;
      if (cmd == rdb_pkg::CMD_COUNT) begin
        mid = longint'(pos) + longint'(len >> 1);
        sa = 2 * (mid / win) + 1;
        sb = 2 * ((2 * mid + win) / (2 * win));
        ok_a = bump(alt, chrom, sa);
        ok_b = bump(alt, chrom, sb);
        if (!ok_a || !ok_b) r.status = rdb_pkg::ST_RANGE;
      end else begin
        c = longint'($signed(coord));
        d = c - 1;
        e = d + (win >> 1);
        found = 0;
        slot = 0;
        if (d >= 0 && d % win == 0) begin
          slot = 2 * (d / win) + 1;
          found = 1;
        end else if (e >= 0 && e % win == 0) begin
          slot = 2 * (e / win);
          found = 1;
        end
        if (found && longint'(chrom) < NCHROM && slot < NSLOT) begin
          idx = longint'(chrom) * NSLOT + slot;
          if (no_alt_tab.exists(idx)) r.no_alt = no_alt_tab[idx];
          if (alt_tab.exists(idx)) r.alt_hit = alt_tab[idx];
        end else begin
          r.status = rdb_pkg::ST_OFFGRID;
        end
      end
      awaited.insert(awaited.size(), r);
    endfunction

    // compare one result transfer with the oldest expectation
    function bit check_result(logic [rdb_pkg::OUT_TDATA_W-1:0] td, output string msg);
      depth_result_t r;
      if (awaited.size() == 0) begin
        msg = $sformatf("result %h with nothing awaited", td);
        return 0;
      end
      r = awaited.pop_front();
      if (td[31:0] !== r.no_alt || td[63:32] !== r.alt_hit || td[65:64] !== r.status) begin
        msg = $sformatf("got no_alt %0d alt %0d status %0d, want %0d %0d %0d",
                        td[31:0], td[63:32], td[65:64], r.no_alt, r.alt_hit, r.status);
        return 0;
      end
      return 1;
    endfunction
  endclass

  typedef struct {
    logic [4:0]  chrom;
    logic [31:0] coord;
  } window_ref_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [rdb_pkg::WIN_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [rdb_pkg::IN_TDATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [rdb_pkg::OUT_TDATA_W-1:0] out_tdata;

  depth_scoreboard sb;
  window_ref_t     seen_windows[$];
  int              mismatches;
  bit              idle_on;
  longint          cur_win;

  windowed_read_depth_binning u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // one command transfer, sometimes with a random gap in front
  task automatic send_cmd(input logic cmd, input logic [4:0] chrom, input logic [30:0] pos,
                          input logic [15:0] len, input logic alt, input logic [31:0] coord);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b0, coord, alt, len, pos, chrom};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, chrom, pos, len, alt, coord);
  endtask

  // random read, mostly landing inside the table
  task automatic send_read();
    longint hi, mid, p;
    logic [15:0] len;
    int r;
    window_ref_t wa, wb;
    r = $urandom_range(0, 9);
    len = (r % 2) ? 16'($urandom) : 16'($urandom_range(0, 300));
    if (r < 6) begin
      hi = cur_win * 4100;
      if (hi > 32'h7FFF_FFFF) hi = 32'h7FFF_FFFF;
      p = $urandom_range(0, 32'(hi));
    end else if (r < 8) begin
      p = cur_win * 4096 - cur_win + $urandom_range(0, 32'(2 * cur_win)) - (len >> 1);
      if (p < 0) p = 0;
      if (p > 32'h7FFF_FFFF) p = 32'h7FFF_FFFF;
    end else begin
      p = $urandom & 32'h7FFF_FFFF;
    end
    mid = p + (len >> 1);
    send_cmd(rdb_pkg::CMD_COUNT, 5'($urandom), 31'(p), len, 1'($urandom), 32'($urandom));
    wa = '{5'($urandom_range(0, 31) == 0 ? $urandom : 0) ^ in_tdata[4:0],
           32'((mid / cur_win) * cur_win + 1)};
    wb = '{in_tdata[4:0],
           32'(((2 * mid + cur_win) / (2 * cur_win)) * cur_win - (cur_win >> 1) + 1)};
    seen_windows.insert(seen_windows.size(), wa);
    seen_windows.insert(seen_windows.size(), wb);
    if (seen_windows.size() > 64) void'(seen_windows.pop_front());
  endtask

  // random query, mostly at the start of a window that holds counts
  task automatic send_query();
    window_ref_t wr;
    longint k;
    int r;
    r = $urandom_range(0, 19);
    k = $urandom_range(0, 4200);
    if (r < 12 && seen_windows.size() > 0) begin
      wr = seen_windows[$urandom_range(0, seen_windows.size() - 1)];
    end else if (r < 15) begin
      wr = '{5'($urandom), 32'(k * cur_win + 1)};
    end else if (r < 18) begin
      wr = '{5'($urandom), 32'(k * cur_win - (cur_win >> 1) + 1)};
    end else begin
      wr = '{5'($urandom), 32'($urandom)};
    end
    send_cmd(rdb_pkg::CMD_QUERY, wr.chrom, 31'($urandom), 16'($urandom), 1'($urandom),
             wr.coord);
  endtask

  // wait until every result is back and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_window(input logic [rdb_pkg::WIN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_window(v);
    cur_win = sb.win;
    seen_windows.delete();
  endtask

  // result side: check each transfer and stall in bursts
  initial begin
    int stall_left;
    string msg;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (!sb.check_result(out_tdata, msg)) report(msg);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [rdb_pkg::WIN_W-1:0] phase_win[9];
    int n;
    sb = new();
    cur_win = rdb_pkg::WIN_RESET;
    mismatches = 0;
    idle_on = 1;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset window width
    send_cmd(rdb_pkg::CMD_COUNT, 5'd0, 31'd0, 16'd0, 1'b0, 32'd0);
    send_cmd(rdb_pkg::CMD_COUNT, 5'd0, 31'd0, 16'd1, 1'b1, 32'd0);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd0, 31'd0, 16'd0, 1'b0, 32'd1);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd0, 31'd0, 16'd0, 1'b0, -32'sd499);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd0, 31'd0, 16'd0, 1'b0, 32'd0);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd0, 31'd0, 16'd0, 1'b0, 32'h8000_0000);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd0, 31'd0, 16'd0, 1'b0, 32'h7FFF_FFFF);
    // read far beyond the table, both windows out of range
    send_cmd(rdb_pkg::CMD_COUNT, 5'd31, 31'h7FFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    // last slot counted, offset window just past the end
    send_cmd(rdb_pkg::CMD_COUNT, 5'd31, 31'd4095999, 16'd0, 1'b0, 32'd0);
    send_cmd(rdb_pkg::CMD_COUNT, 5'd31, 31'd4095998, 16'd2, 1'b1, 32'd0);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd31, 31'd0, 16'd0, 1'b0, 32'd4095001);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd31, 31'd0, 16'd0, 1'b0, 32'd4095501);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd31, 31'd0, 16'd0, 1'b0, 32'd4094501);
    send_cmd(rdb_pkg::CMD_COUNT, 5'd5, 31'd1500, 16'd0, 1'b0, 32'd0);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd5, 31'd0, 16'd0, 1'b0, 32'd1001);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd5, 31'd0, 16'd0, 1'b0, 32'd1501);
    send_cmd(rdb_pkg::CMD_QUERY, 5'd5, 31'd0, 16'd0, 1'b0, 32'd1502);
    drain();

    // random phases over several window widths, the clamps among them
    phase_win = '{21'd1000, 21'd2, 21'd0, 21'd1048576, 21'h1FFFFF,
                  21'd3, 21'd7777, 21'($urandom_range(2, 5000)), 21'd1};
    foreach (phase_win[i]) begin
      write_window(phase_win[i]);
      if (i == 8) idle_on = 0;
      n = 150 + $urandom_range(0, 20);
      repeat (n) begin
        if ($urandom_range(0, 9) < 6) send_read();
        else send_query();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
